/* hw/rtl/rag_pkg.sv */
`default_nettype none

package rag_pkg;

  localparam int SAMPLE_WIDTH     = 24;
  localparam int GAIN_WIDTH       = 24;
  localparam int GAIN_FRAC_BITS   = 20;
  localparam int ACC_EXTRA_BITS   = 16;
  localparam int URF_WIDTH        = 16;
  localparam int CCNT_WIDTH       = 4;
  localparam int CFG_IDX_WIDTH    = 2;
  localparam int CFG_DATA_WIDTH   = 24;
  localparam int MAX_CHANNELS_DEF = 8;
  localparam int CHAN_LIM_WIDTH   = 5;

  // gain difference carries one more bit than a gain
  localparam int DIFF_WIDTH    = GAIN_WIDTH + 1;
  localparam int ACC_WIDTH     = GAIN_WIDTH + ACC_EXTRA_BITS + 1;
  localparam int LENP_WIDTH    = URF_WIDTH + DIFF_WIDTH;
  localparam int DIV_STEPS     = DIFF_WIDTH + ACC_EXTRA_BITS;
  localparam int DIV_CNT_WIDTH = $clog2(DIV_STEPS + 1);
  localparam int PROD_WIDTH    = SAMPLE_WIDTH + GAIN_WIDTH;

  // |d| * 100000 < 2 * 2^frac  <=>  |d| < NEAR_LIM
  localparam int NEAR_LIM = ((2 ** (GAIN_FRAC_BITS + 1)) + 99999) / 100000;

  localparam logic signed [GAIN_WIDTH-1:0] GAIN_GOAL_RST = GAIN_WIDTH'(1 << GAIN_FRAC_BITS);
  localparam logic [URF_WIDTH-1:0]         URF_RST       = URF_WIDTH'(2400);
  localparam logic [CCNT_WIDTH-1:0]        CCNT_RST      = CCNT_WIDTH'(2);

  typedef enum logic [CFG_IDX_WIDTH-1:0] {
    CFG_GAIN_GOAL  = 2'd0,
    CFG_UNITY_RAMP = 2'd1,
    CFG_CHAN_NUM   = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] sample_in;
    logic                           last_of_buffer;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] sample_out;
    logic                           ramping;
  } out_item_t;

  typedef struct packed {
    logic capture;
    logic start_close;
    logic jump;
    logic len_calc;
    logic ramp_load;
    logic div_iter;
    logic step_store;
    logic frame;
    logic mul;
    logic out_write;
  } cmd_t;

  typedef struct packed {
    logic buf_start;
    logic initialized;
    logic gain_eq;
    logic len_zero;
    logic div_last;
    logic out_blocked;
  } sts_t;

endpackage

`default_nettype wire

/* hw/rtl/ramped_audio_gain.sv */
// Gain stage for interleaved 24-bit audio with linear ramp smoothing. Samples are
// processed one at a time: a sample passes the start, frame, multiply and output
// states from transfer in to result registered, and the next sample is taken on
// the cycle after that, even if the result has not been transferred out yet. A
// buffer start whose ramp length comes out zero also passes the length state. At
// the first sample of a buffer whose gain differs from the target gain, except in
// the first buffer after reset, which jumps to the target, the ramp length is
// formed with one multiply and, if it is nonzero, the per-frame step with a
// restoring divider that yields one quotient bit per cycle. A result that finds
// the previous one still waiting holds the block until that one is taken.
// Register writes to the target gain and the ramp frames per unit change act at
// the next buffer start, the channel count at the next frame boundary; write them
// only while no sample is in flight.
`default_nettype none

module ramped_audio_gain #(
  parameter int MAX_CHANNELS = rag_pkg::MAX_CHANNELS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire rag_pkg::in_item_t                   in_data,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output rag_pkg::out_item_t                       out_data,
  input  wire logic                                cfg_we,
  input  wire logic [rag_pkg::CFG_IDX_WIDTH-1:0]   cfg_index,
  input  wire logic [rag_pkg::CFG_DATA_WIDTH-1:0]  cfg_wdata
);

  rag_pkg::cmd_t cmd;
  rag_pkg::sts_t sts;

  rag_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .sts      (sts),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  rag_datapath #(
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cmd       (cmd),
    .sts       (sts)
  );

`ifndef SYNTHESIS
  // a finished result never overwrites one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_write |-> !(out_valid && out_stall))
    else $error("result written over a pending result");

  // one sample in flight at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("second sample taken while one is in flight");

  // a ramp only starts with a nonzero length
  a_ramp_len: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ramp_load |-> !sts.len_zero)
    else $error("ramp started with zero length");

  // the step is stored right after the last divider iteration
  a_step_after_div: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step_store |-> $past(cmd.div_iter && sts.div_last))
    else $error("ramp step stored before division finished");
`endif

endmodule

`default_nettype wire

/* hw/rtl/rag_ctrl.sv */
`default_nettype none

module rag_ctrl (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  input  wire rag_pkg::sts_t sts,
  output logic              in_stall,
  output rag_pkg::cmd_t     cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_LEN,
    S_DIV,
    S_STEP,
    S_FRAME,
    S_MUL,
    S_OUT
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_START;
        end
      end
      S_START: begin
        if (!sts.buf_start) begin
          state_nxt = S_FRAME;
        end else if (!sts.initialized) begin
          // first buffer after reset: jump straight to the target
          cmd.jump        = 1'b1;
          cmd.start_close = 1'b1;
          state_nxt       = S_FRAME;
        end else if (sts.gain_eq) begin
          cmd.start_close = 1'b1;
          state_nxt       = S_FRAME;
        end else begin
          cmd.len_calc = 1'b1;
          state_nxt    = S_LEN;
        end
      end
      S_LEN: begin
        cmd.start_close = 1'b1;
        if (sts.len_zero) begin
          state_nxt = S_FRAME;
        end else begin
          cmd.ramp_load = 1'b1;
          state_nxt     = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_iter = 1'b1;
        if (sts.div_last) begin
          state_nxt = S_STEP;
        end
      end
      S_STEP: begin
        cmd.step_store = 1'b1;
        state_nxt      = S_FRAME;
      end
      S_FRAME: begin
        cmd.frame = 1'b1;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!sts.out_blocked) begin
          cmd.out_write = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

endmodule

`default_nettype wire

/* hw/rtl/rag_datapath.sv */
`default_nettype none

module rag_datapath #(
  parameter int MAX_CHANNELS = rag_pkg::MAX_CHANNELS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cfg_we,
  input  wire logic [rag_pkg::CFG_IDX_WIDTH-1:0]   cfg_index,
  input  wire logic [rag_pkg::CFG_DATA_WIDTH-1:0]  cfg_wdata,
  input  wire rag_pkg::in_item_t                   in_data,
  input  wire logic                                out_stall,
  output logic                                     out_valid,
  output rag_pkg::out_item_t                       out_data,
  input  wire rag_pkg::cmd_t                       cmd,
  output rag_pkg::sts_t                            sts
);

  localparam int PW   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int CLW  = rag_pkg::CHAN_LIM_WIDTH;
  localparam int GW   = rag_pkg::GAIN_WIDTH;
  localparam int SW   = rag_pkg::SAMPLE_WIDTH;
  localparam int DW   = rag_pkg::DIFF_WIDTH;
  localparam int AW   = rag_pkg::ACC_WIDTH;
  localparam int XB   = rag_pkg::ACC_EXTRA_BITS;
  localparam int FB   = rag_pkg::GAIN_FRAC_BITS;
  localparam int UW   = rag_pkg::URF_WIDTH;
  localparam int LPW  = rag_pkg::LENP_WIDTH;
  localparam int PRW  = rag_pkg::PROD_WIDTH;
  localparam int CNW  = rag_pkg::DIV_CNT_WIDTH;
  localparam int LFW  = LPW - FB;

  // configuration
  logic signed [GW-1:0]                 target_r;
  logic [UW-1:0]                        urf_r;
  logic [rag_pkg::CCNT_WIDTH-1:0]       ccnt_r;

  // gain and ramp state
  logic signed [GW-1:0] cur_r,        cur_nxt;
  logic signed [GW-1:0] rtarget_r,    rtarget_nxt;
  logic signed [AW-1:0] step_r,       step_nxt;
  logic signed [AW-1:0] acc_r,        acc_nxt;
  logic [UW-1:0]        left_r,       left_nxt;
  logic [PW-1:0]        pos_r,        pos_nxt;
  logic                 init_r,       init_nxt;
  logic                 bstart_r,     bstart_nxt;
  logic                 framp_r,      framp_nxt;
  logic                 out_valid_r,  out_valid_nxt;

  // payload
  logic signed [SW-1:0]  sample_r;
  logic                  last_r;
  logic signed [DW-1:0]  diff_r;
  logic [LPW-1:0]        lenp_r;
  logic [AW-1:0]         div_q_r;
  logic [UW:0]           div_rem_r;
  logic [UW-1:0]         div_len_r;
  logic [CNW-1:0]        div_cnt_r;
  logic signed [PRW-1:0] mul_r;
  logic                  m_ramp_r;
  logic                  m_unity_r;
  logic                  m_zero_r;
  rag_pkg::out_item_t    out_data_r;

  // combinational
  logic signed [DW-1:0]  diff_c;
  logic [DW-1:0]         absdiff_c;
  logic [LFW-1:0]        len_full;
  logic [UW-1:0]         len_c;
  logic [CLW-1:0]        chan_lim;
  logic [CLW-1:0]        pos_ext;
  logic [CLW-1:0]        pos_inc;
  logic [PW-1:0]         pos_eff;
  logic signed [AW-1:0]  acc_sum;
  logic [UW-1:0]         left_m1;
  logic [UW:0]           rem_sh;
  logic                  rem_ge;
  logic signed [DW-1:0]  d_unity;
  logic signed [DW-1:0]  d_zero;
  logic signed [PRW:0]   rnd_sum;
  logic signed [PRW-FB:0] rnd_shift;
  logic signed [SW-1:0]  sat_c;
  logic signed [SW-1:0]  y_c;

  // magnitude of the stored gain difference
  function automatic logic [DW-1:0] absdiff_c_hold(input logic signed [DW-1:0] d);
    absdiff_c_hold = d[DW-1] ? DW'(-d) : DW'(d);
  endfunction

  assign diff_c    = DW'(target_r) - DW'(cur_r);
  assign absdiff_c = diff_c[DW-1] ? DW'(-diff_c) : DW'(diff_c);

  assign len_full = lenp_r[LPW-1:FB];
  assign len_c    = (len_full > LFW'({UW{1'b1}})) ? {UW{1'b1}} : len_full[UW-1:0];

  always_comb begin
    if (ccnt_r == '0) begin
      chan_lim = CLW'(1);
    end else if (CLW'(ccnt_r) > CLW'(MAX_CHANNELS)) begin
      chan_lim = CLW'(MAX_CHANNELS);
    end else begin
      chan_lim = CLW'(ccnt_r);
    end
  end

  // channel count may have shrunk since the last sample
  assign pos_ext = CLW'(pos_r);
  assign pos_eff = (pos_ext >= chan_lim) ? '0 : pos_r;
  assign pos_inc = CLW'(pos_r) + CLW'(1);

  assign acc_sum = acc_r + step_r;
  assign left_m1 = left_r - UW'(1);

  // restoring divider, one quotient bit per cycle
  assign rem_sh = {div_rem_r[UW-1:0], div_q_r[AW-1]};
  assign rem_ge = (rem_sh >= {1'b0, div_len_r});

  assign d_unity = DW'(cur_r) - DW'(1 << FB);
  assign d_zero  = DW'(cur_r);

  // round half up, then floor by the fraction bits
  assign rnd_sum   = (PRW+1)'(mul_r) + (PRW+1)'(1 << (FB - 1));
  assign rnd_shift = rnd_sum[PRW:FB];

  always_comb begin
    if (rnd_shift > (PRW-FB+1)'((1 << (SW - 1)) - 1)) begin
      sat_c = {1'b0, {(SW-1){1'b1}}};
    end else if (rnd_shift < -(PRW-FB+1)'(1 << (SW - 1))) begin
      sat_c = {1'b1, {(SW-1){1'b0}}};
    end else begin
      sat_c = rnd_shift[SW-1:0];
    end
  end

  always_comb begin
    if (m_ramp_r) begin
      y_c = sat_c;
    end else if (m_unity_r) begin
      y_c = sample_r;
    end else if (m_zero_r) begin
      y_c = '0;
    end else begin
      y_c = sat_c;
    end
  end

  // control state next values
  always_comb begin
    cur_nxt       = cur_r;
    rtarget_nxt   = rtarget_r;
    step_nxt      = step_r;
    acc_nxt       = acc_r;
    left_nxt      = left_r;
    pos_nxt       = pos_r;
    init_nxt      = init_r;
    bstart_nxt    = bstart_r;
    framp_nxt     = framp_r;
    out_valid_nxt = out_valid_r;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.out_write) begin
      out_valid_nxt = 1'b1;
    end

    if (cmd.jump) begin
      cur_nxt = target_r;
    end
    if (cmd.start_close) begin
      init_nxt   = 1'b1;
      bstart_nxt = 1'b0;
    end
    if (cmd.ramp_load) begin
      acc_nxt     = {cur_r[GW-1], cur_r, {XB{1'b0}}};
      left_nxt    = len_c;
      rtarget_nxt = target_r;
    end
    if (cmd.step_store) begin
      step_nxt = diff_r[DW-1] ? -$signed(div_q_r) : $signed(div_q_r);
    end

    if (cmd.frame) begin
      pos_nxt = pos_eff;
      if (pos_eff == '0) begin
        framp_nxt = 1'b0;
        if (left_r != '0) begin
          framp_nxt = 1'b1;
          left_nxt  = left_m1;
          acc_nxt   = acc_sum;
          if (left_m1 == '0) begin
            cur_nxt = rtarget_r;
          end else begin
            cur_nxt = acc_sum[XB +: GW];
          end
        end
      end
    end

    if (cmd.mul) begin
      if (last_r) begin
        bstart_nxt = 1'b1;
        pos_nxt    = '0;
        left_nxt   = '0;
        framp_nxt  = 1'b0;
      end else if (pos_inc >= chan_lim) begin
        pos_nxt = '0;
      end else begin
        pos_nxt = pos_inc[PW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r    <= rag_pkg::GAIN_GOAL_RST;
      urf_r       <= rag_pkg::URF_RST;
      ccnt_r      <= rag_pkg::CCNT_RST;
      cur_r       <= '0;
      rtarget_r   <= '0;
      step_r      <= '0;
      acc_r       <= '0;
      left_r      <= '0;
      pos_r       <= '0;
      init_r      <= 1'b0;
      bstart_r    <= 1'b1;
      framp_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (rag_pkg::cfg_reg_t'(cfg_index))
          rag_pkg::CFG_GAIN_GOAL:  target_r <= cfg_wdata[GW-1:0];
          rag_pkg::CFG_UNITY_RAMP: urf_r    <= cfg_wdata[UW-1:0];
          rag_pkg::CFG_CHAN_NUM:   ccnt_r   <= cfg_wdata[rag_pkg::CCNT_WIDTH-1:0];
          default: begin
          end
        endcase
      end
      cur_r       <= cur_nxt;
      rtarget_r   <= rtarget_nxt;
      step_r      <= step_nxt;
      acc_r       <= acc_nxt;
      left_r      <= left_nxt;
      pos_r       <= pos_nxt;
      init_r      <= init_nxt;
      bstart_r    <= bstart_nxt;
      framp_r     <= framp_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      sample_r <= in_data.sample_in;
      last_r   <= in_data.last_of_buffer;
    end
    if (cmd.len_calc) begin
      diff_r <= diff_c;
      lenp_r <= LPW'(urf_r) * LPW'(absdiff_c);
    end
    if (cmd.ramp_load) begin
      div_q_r   <= {absdiff_c_hold(diff_r), {XB{1'b0}}};
      div_rem_r <= '0;
      div_len_r <= len_c;
      div_cnt_r <= CNW'(rag_pkg::DIV_STEPS);
    end else if (cmd.div_iter) begin
      div_q_r   <= {div_q_r[AW-2:0], rem_ge};
      div_rem_r <= rem_ge ? (rem_sh - {1'b0, div_len_r}) : rem_sh;
      div_cnt_r <= div_cnt_r - CNW'(1);
    end
    if (cmd.mul) begin
      mul_r     <= PRW'(sample_r) * PRW'(cur_r);
      m_ramp_r  <= framp_r;
      m_unity_r <= (d_unity < DW'(rag_pkg::NEAR_LIM)) && (d_unity > -DW'(rag_pkg::NEAR_LIM));
      m_zero_r  <= (d_zero < DW'(rag_pkg::NEAR_LIM)) && (d_zero > -DW'(rag_pkg::NEAR_LIM));
    end
    if (cmd.out_write) begin
      out_data_r.sample_out <= y_c;
      out_data_r.ramping    <= m_ramp_r;
    end
  end

  assign sts.buf_start   = bstart_r;
  assign sts.initialized = init_r;
  assign sts.gain_eq     = (cur_r == target_r);
  assign sts.len_zero    = (len_c == '0);
  assign sts.div_last    = (div_cnt_r == CNW'(1));
  assign sts.out_blocked = out_valid_r && out_stall;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

/* verif/gain_stage_checker.sv */
`timescale 1ns / 1ps

module gain_stage_checker (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  input  logic                                 in_stall,
  input  rag_pkg::in_item_t                    in_data,
  input  logic                                 out_valid,
  input  logic                                 out_stall,
  input  rag_pkg::out_item_t                   out_data,
  input  logic                                 cfg_we,
  input  logic [rag_pkg::CFG_IDX_WIDTH-1:0]    cfg_index,
  input  logic [rag_pkg::CFG_DATA_WIDTH-1:0]   cfg_wdata,
  output int                                   n_errors,
  output int                                   n_pending,
  output int                                   n_ramped
);
  import rag_pkg::*;

  localparam longint UNITY      = 64'sd1 <<< GAIN_FRAC_BITS;
  localparam longint NEAR_BOUND = 64'sd2 <<< GAIN_FRAC_BITS;
  localparam longint ROUND_HALF = 64'sd1 <<< (GAIN_FRAC_BITS - 1);
  localparam longint ACC_ONE    = 64'sd1 <<< ACC_EXTRA_BITS;
  localparam longint LEN_CAP    = 64'sd65535;
  localparam longint OUT_MAX    = (64'sd1 <<< (SAMPLE_WIDTH - 1)) - 64'sd1;
  localparam longint OUT_MIN    = -(64'sd1 <<< (SAMPLE_WIDTH - 1));
  localparam int     REPORT_LIMIT = 10;

  // register copies
  longint tgt_gain;
  longint ramp_unit;
  int     chan_cfg;

  // gain stage state
  longint gain;
  longint step;
  longint acc;
  longint ramp_goal;
  int     frames_left;
  int     chan_pos;
  bit     primed;
  bit     buf_start;
  bit     in_ramp_frame;

  rag_pkg::out_item_t scaled_due[$];
  int fault_count;
  int results_seen;
  int ramp_results;

  function automatic longint magnitude(longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic bit within_band(longint d);
    return magnitude(d) * 64'sd100000 < NEAR_BOUND;
  endfunction

  function automatic longint mul_round_sat(longint s, longint g);
    longint r;
    r = (s * g + ROUND_HALF) >>> GAIN_FRAC_BITS;
    if (r > OUT_MAX) r = OUT_MAX;
    if (r < OUT_MIN) r = OUT_MIN;
    return r;
  endfunction

  function automatic rag_pkg::out_item_t scale_next_sample(rag_pkg::in_item_t it);
    longint s;
    longint d;
    longint len;
    longint y;
    int chans;
    rag_pkg::out_item_t r;
    s = $signed(it.sample_in);
    chans = chan_cfg;
    if (chans == 0) chans = 1;
    if (chans > MAX_CHANNELS_DEF) chans = MAX_CHANNELS_DEF;
    if (chan_pos >= chans) chan_pos = 0;

    if (buf_start) begin
      if (gain != tgt_gain) begin
        if (primed) begin
          d = tgt_gain - gain;
          len = (ramp_unit * magnitude(d)) >>> GAIN_FRAC_BITS;
          if (len > LEN_CAP) len = LEN_CAP;
          // zero length leaves the gain where it is
          if (len > 0) begin
            step = (d * ACC_ONE) / len;
            acc = gain * ACC_ONE;
            frames_left = int'(len);
            ramp_goal = tgt_gain;
          end
        end else begin
          gain = tgt_gain;
        end
      end
      primed = 1'b1;
      buf_start = 1'b0;
    end

    if (chan_pos == 0) begin
      in_ramp_frame = 1'b0;
      if (frames_left > 0) begin
        in_ramp_frame = 1'b1;
        frames_left--;
        acc += step;
        // final ramp frame lands exactly on the target
        gain = (frames_left == 0) ? ramp_goal : (acc >>> ACC_EXTRA_BITS);
      end
    end

    if (in_ramp_frame) y = mul_round_sat(s, gain);
    else if (within_band(gain - UNITY)) y = s;
    else if (within_band(gain)) y = 0;
    else y = mul_round_sat(s, gain);

    r.sample_out = y[SAMPLE_WIDTH-1:0];
    r.ramping = in_ramp_frame;

    chan_pos++;
    if (chan_pos >= chans) chan_pos = 0;
    if (it.last_of_buffer) begin
      buf_start = 1'b1;
      chan_pos = 0;
      frames_left = 0;
      in_ramp_frame = 1'b0;
    end
    return r;
  endfunction

  always @(posedge clk) begin : watch
    rag_pkg::out_item_t due;
    if (!rst_n) begin
      tgt_gain = $signed(GAIN_GOAL_RST);
      ramp_unit = longint'(URF_RST);
      chan_cfg = int'(CCNT_RST);
      gain = 0;
      step = 0;
      acc = 0;
      ramp_goal = 0;
      frames_left = 0;
      chan_pos = 0;
      primed = 1'b0;
      buf_start = 1'b1;
      in_ramp_frame = 1'b0;
      scaled_due.delete();
      fault_count = 0;
      results_seen = 0;
      ramp_results = 0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (scaled_due.size() == 0) begin
          fault_count++;
          if (fault_count <= REPORT_LIMIT)
            $display("result %0d with no sample pending: sample %h ramping %b",
                     results_seen, out_data.sample_out, out_data.ramping);
        end else begin
          due = scaled_due.pop_front();
          if (due.ramping) ramp_results++;
          if (due.sample_out !== out_data.sample_out || due.ramping !== out_data.ramping) begin
            fault_count++;
            if (fault_count <= REPORT_LIMIT)
              $display({"mismatch on result %0d: expected sample %h ramping %b,",
                        " got sample %h ramping %b"},
                       results_seen, due.sample_out, due.ramping,
                       out_data.sample_out, out_data.ramping);
          end
        end
      end

      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          CFG_GAIN_GOAL: tgt_gain = $signed(cfg_wdata[GAIN_WIDTH-1:0]);
          CFG_UNITY_RAMP: ramp_unit = longint'(cfg_wdata[URF_WIDTH-1:0]);
          CFG_CHAN_NUM: chan_cfg = int'(cfg_wdata[CCNT_WIDTH-1:0]);
          default: ;
        endcase
      end

      if (in_valid && !in_stall) scaled_due.push_back(scale_next_sample(in_data));
    end
    n_pending <= scaled_due.size();
    n_errors <= fault_count;
    n_ramped <= ramp_results;
  end

endmodule

/* verif/tb_ramped_audio_gain.sv */
`timescale 1ns / 1ps

module tb_ramped_audio_gain;
  import rag_pkg::*;

  localparam int RANDOM_ITEMS  = 1850;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int SETTLE_CYCLES = 8;
  localparam int TAIL_CYCLES   = 64;
  localparam int UNITY         = 1 << GAIN_FRAC_BITS;
  localparam logic [SAMPLE_WIDTH-1:0] S_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic [SAMPLE_WIDTH-1:0] S_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
  localparam logic [SAMPLE_WIDTH-1:0] S_ONE = SAMPLE_WIDTH'(1);
  localparam logic [SAMPLE_WIDTH-1:0] S_NEG_ONE = '1;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_WIDTH-1:0] cfg_index = '0;
  logic [CFG_DATA_WIDTH-1:0] cfg_wdata = '0;

  int n_errors;
  int n_pending;
  int n_ramped;
  int cycle_count = 0;
  int burst_left = 0;
  int n_sent = 0;
  int n_buffers = 0;
  int n_settings = 0;
  int chans_now = int'(CCNT_RST);
  int directed_items;

  ramped_audio_gain uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  gain_stage_checker checker_i (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .n_errors(n_errors),
    .n_pending(n_pending),
    .n_ramped(n_ramped)
  );

  initial begin : clock_gen
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin : watchdog
    wait (cycle_count >= CYCLE_LIMIT);
    $display("timeout after %0d cycles with %0d results outstanding", cycle_count, n_pending);
    $display("tb_ramped_audio_gain NOT OK");
    $finish;
  end

  // receiver back-pressure: segments of free flow, light, heavy and near-constant stalls
  initial begin : rx_pattern
    int mode;
    int span;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(20, 300);
      repeat (span) begin
        @(posedge clk);
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          2: out_stall <= 1'($urandom_range(0, 1));
          default: out_stall <= ($urandom_range(0, 9) != 0);
        endcase
      end
    end
  end

  function automatic logic [SAMPLE_WIDTH-1:0] pick_sample();
    int v;
    case ($urandom_range(0, 9))
      0: return S_MAX;
      1: return S_MIN;
      2: return '0;
      3: begin
        v = int'($urandom_range(0, 512)) - 256;
        return v[SAMPLE_WIDTH-1:0];
      end
      default: return SAMPLE_WIDTH'($urandom);
    endcase
  endfunction

  function automatic logic [CFG_DATA_WIDTH-1:0] pick_target();
    int v;
    case ($urandom_range(0, 7))
      0: v = UNITY;
      1: v = UNITY + int'($urandom_range(0, 60)) - 30;
      2: v = int'($urandom_range(0, 60)) - 30;
      3: v = -(1 << (GAIN_WIDTH - 1));
      4: v = (1 << (GAIN_WIDTH - 1)) - 1;
      5: v = int'($urandom_range(0, 4 * UNITY)) - 2 * UNITY;
      default: v = int'($urandom);
    endcase
    return v[CFG_DATA_WIDTH-1:0];
  endfunction

  function automatic logic [CFG_DATA_WIDTH-1:0] pick_ramp_frames();
    logic [CFG_DATA_WIDTH-1:0] w;
    w = CFG_DATA_WIDTH'($urandom);
    case ($urandom_range(0, 7))
      0: w[URF_WIDTH-1:0] = '0;
      1: w[URF_WIDTH-1:0] = URF_WIDTH'($urandom_range(1, 16));
      2, 3: w[URF_WIDTH-1:0] = URF_WIDTH'($urandom_range(17, 400));
      4: w[URF_WIDTH-1:0] = '1;
      5: w[URF_WIDTH-1:0] = URF_WIDTH'($urandom_range(401, 4000));
      default: ;
    endcase
    return w;
  endfunction

  function automatic logic [CFG_DATA_WIDTH-1:0] pick_channels();
    logic [CFG_DATA_WIDTH-1:0] w;
    w = CFG_DATA_WIDTH'($urandom);
    case ($urandom_range(0, 9))
      0: w[CCNT_WIDTH-1:0] = '0;
      1: w[CCNT_WIDTH-1:0] = CCNT_WIDTH'($urandom_range(MAX_CHANNELS_DEF + 1, 15));
      default: w[CCNT_WIDTH-1:0] = CCNT_WIDTH'($urandom_range(1, MAX_CHANNELS_DEF));
    endcase
    return w;
  endfunction

  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_WIDTH-1:0] val);
    int c;
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == CFG_CHAN_NUM) begin
      c = int'(val[CCNT_WIDTH-1:0]);
      chans_now = (c == 0) ? 1 : (c > MAX_CHANNELS_DEF) ? MAX_CHANNELS_DEF : c;
    end
  endtask

  // one sample transfer, opening a new burst with a random gap when the last one ran out
  task automatic push_sample(logic [SAMPLE_WIDTH-1:0] smp, logic last);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 400) : $urandom_range(1, 30);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data <= '{sample_in: smp, last_of_buffer: last};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    n_sent++;
    if (last) n_buffers++;
  endtask

  // hold the sender until every result is back, then let the pipeline settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (n_pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic send_buffer(int len, bit closed);
    for (int k = 0; k < len; k++) push_sample(pick_sample(), closed && (k == len - 1));
  endtask

  task automatic random_phase();
    int budget;
    int len;
    bit wrote;
    wrote = 1'b0;
    if ($urandom_range(0, 2) != 0) begin
      write_reg(CFG_GAIN_GOAL, pick_target());
      wrote = 1'b1;
    end
    if ($urandom_range(0, 2) != 0) begin
      write_reg(CFG_UNITY_RAMP, pick_ramp_frames());
      wrote = 1'b1;
    end
    if ($urandom_range(0, 3) == 0 || !wrote) write_reg(CFG_CHAN_NUM, pick_channels());
    n_settings++;
    budget = $urandom_range(30, 250);
    // keep the whole run at the planned number of samples
    if (budget > directed_items + RANDOM_ITEMS - n_sent)
      budget = directed_items + RANDOM_ITEMS - n_sent;
    while (budget > 0) begin
      case ($urandom_range(0, 9))
        0: len = $urandom_range(1, 3 * chans_now);
        1: len = chans_now * $urandom_range(25, 120);
        default: len = chans_now * $urandom_range(1, 16);
      endcase
      if (len > budget) begin
        // phase may stop mid-buffer, so the next register writes land inside it
        send_buffer(budget, 1'($urandom_range(0, 1)));
        budget = 0;
      end else begin
        send_buffer(len, 1'b1);
        budget -= len;
      end
      if ($urandom_range(0, 15) == 0) wait_idle();
    end
    wait_idle();
  endtask

  initial begin : stimulus
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // first buffer after reset jumps to unity and passes samples through
    push_sample(S_MAX, 1'b0);
    push_sample(S_MIN, 1'b0);
    push_sample('0, 1'b0);
    push_sample(S_NEG_ONE, 1'b1);
    wait_idle();

    // half gain over an 8-frame ramp, mono, ending on the target
    write_reg(CFG_GAIN_GOAL, CFG_DATA_WIDTH'(UNITY / 2));
    write_reg(CFG_UNITY_RAMP, CFG_DATA_WIDTH'(16));
    write_reg(CFG_CHAN_NUM, CFG_DATA_WIDTH'(1));
    n_settings++;
    push_sample(S_MAX, 1'b0);
    push_sample(S_MIN, 1'b0);
    push_sample(S_ONE, 1'b0);
    push_sample(S_NEG_ONE, 1'b0);
    send_buffer(4, 1'b0);
    push_sample(S_MAX, 1'b1);
    wait_idle();

    // most negative target with the longest ramp, cut short by the buffer end
    write_reg(CFG_GAIN_GOAL, {1'b1, {(CFG_DATA_WIDTH-1){1'b0}}});
    write_reg(CFG_UNITY_RAMP, {{(CFG_DATA_WIDTH-URF_WIDTH){1'b0}}, {URF_WIDTH{1'b1}}});
    write_reg(CFG_CHAN_NUM, '0);
    n_settings++;
    push_sample(S_MAX, 1'b0);
    push_sample(S_MIN, 1'b0);
    push_sample(S_MAX, 1'b1);
    wait_idle();

    // zero ramp length keeps the gain; channel count above range, buffer ends mid-frame
    write_reg(CFG_GAIN_GOAL, {1'b0, {(CFG_DATA_WIDTH-1){1'b1}}});
    write_reg(CFG_UNITY_RAMP, '0);
    write_reg(CFG_CHAN_NUM, CFG_DATA_WIDTH'(15));
    n_settings++;
    push_sample(S_MAX, 1'b0);
    push_sample(S_MIN, 1'b0);
    push_sample(S_ONE, 1'b0);
    push_sample(S_NEG_ONE, 1'b1);
    wait_idle();

    // short ramp down to zero, then muted frames
    write_reg(CFG_GAIN_GOAL, '0);
    write_reg(CFG_UNITY_RAMP, CFG_DATA_WIDTH'(4));
    write_reg(CFG_CHAN_NUM, CFG_DATA_WIDTH'(1));
    n_settings++;
    push_sample(S_MAX, 1'b0);
    push_sample(S_MIN, 1'b0);
    push_sample(S_MAX, 1'b0);
    push_sample(S_MIN, 1'b0);
    push_sample(S_ONE, 1'b1);
    wait_idle();
    directed_items = n_sent;

    while (n_sent < directed_items + RANDOM_ITEMS) random_phase();

    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("summary: %0d samples in %0d closed buffers under %0d register settings",
             n_sent, n_buffers, n_settings);
    $display("summary: %0d results came from ramp frames, %0d mismatches", n_ramped, n_errors);
    if (n_errors == 0 && n_pending == 0) begin
      $display("tb_ramped_audio_gain OK");
    end else begin
      $display("tb_ramped_audio_gain NOT OK");
    end
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/rag_pkg.sv
hw/rtl/rag_ctrl.sv
hw/rtl/rag_datapath.sv
hw/rtl/ramped_audio_gain.sv
verif/gain_stage_checker.sv
verif/tb_ramped_audio_gain.sv
